// File: sv/phcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package phcl_pkg;

  // Request codes.
  localparam logic [1:0] REQ_CONNECT    = 2'd0;
  localparam logic [1:0] REQ_DISCONNECT = 2'd1;
  localparam logic [1:0] REQ_SET_LIMIT  = 2'd2;

  // Action codes.
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_KILL = 2'd1;
  localparam logic [1:0] ACT_BAN  = 2'd2;
  localparam logic [1:0] ACT_FULL = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VIOLATIONS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAN_SECONDS    = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] DEFAULT_LIMIT_RST  = 16'd3;
  localparam logic [15:0] MAX_VIOL_RST       = 16'd5;
  localparam logic [31:0] BAN_SECONDS_RST    = 32'd18000;

  // Counter saturation value.
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Hash mixing constant.
  localparam logic [31:0] HASH_MULT = 32'h045d9f3b;

  // Bucket reduction: high half of the reciprocal product, the quotient and
  // the remainder, in that order.
  localparam int unsigned MOD_STEPS = 3;
  localparam int unsigned STEP_W    = $clog2(MOD_STEPS);

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] host_key;
    logic        has_exception;
    logic [15:0] exception_limit;
  } req_in_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  action;
    logic        exempt_flag;
    logic        entry_found;
    logic [15:0] conn_count;
    logic [15:0] entry_limit;
    logic [15:0] violation_count;
    logic [31:0] ban_time;
  } result_t;

  // One way of a table bucket.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [15:0] count;
    logic [15:0] limit;
    logic [15:0] viol;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic capture;
    logic hash;
    logic mod_init;
    logic mod_step;
    logic read;
    logic lookup;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic mod_last;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/per_host_connection_limiter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-host connection limiter.
// A request (connect, disconnect or set limit for one host key) is taken when
// start is high while busy is low. The block hashes the key to one bucket of
// a set-associative table, reads the bucket row, updates the matching or a
// free way and writes the row back. Exactly one result is shown on result
// for one cycle with done high, after the request was taken; the
// receiver cannot stall it. Busy is high from the accepting edge until the
// cycle that shows the result, in which a new request may already be taken.
// The request passes the hash multiply, the second xor-shift, the bucket
// reduction (a multiply by the reciprocal of BUCKETS, the quotient and the
// remainder), the memory read, the lookup and the write-back, in that order.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data while the block is idle; the user is bound to this, the block
// itself does not enforce it. A write to an unused index is ignored.
// After reset the table is cleared one bucket per cycle, with busy high;
// configuration writes are taken during that pass.
module per_host_connection_limiter_top #(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned WAYS    = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire phcl_pkg::req_in_t               req,
  output      logic                            done,
  output      phcl_pkg::result_t               result,
  input  wire logic                            cfg_we,
  input  wire logic [phcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [phcl_pkg::CFG_DATA_W-1:0] cfg_data
);

  phcl_pkg::cmd_t cmd;
  phcl_pkg::sts_t sts;

  // Sequencing of the clearing pass and of each request.
  phcl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Hash, bucket table and update logic.
  phcl_dpath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  // Every accepted request gets its result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##9 done)
    else $error("result missing after an accepted request");

  // Result strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

endmodule

`default_nettype wire

// File: sv/phcl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module phcl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/phcl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module phcl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output      logic            busy,
  input  wire phcl_pkg::sts_t  sts,
  output      phcl_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_HASH   = 8'b0000_0100,
    S_MIX    = 8'b0000_1000,
    S_MOD    = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_LOOKUP = 8'b0100_0000,
    S_UPDATE = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the table clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash   = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mod_init = 1'b1;
        state_next   = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // The reduction leaves for the bucket read only on its last step.
  a_mod_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) && !sts.mod_last |=> (state == S_MOD))
    else $error("bucket reduction left early");

  // An update is always followed by a return to idle.
  a_update_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (state == S_IDLE) && !busy)
    else $error("controller did not return to idle after update");

endmodule

`default_nettype wire

// File: sv/phcl_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module phcl_dpath #(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned WAYS    = 4
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire phcl_pkg::cmd_t                       cmd,
  output      phcl_pkg::sts_t                       sts,
  input  wire phcl_pkg::req_in_t                    req,
  input  wire logic                                 cfg_we,
  input  wire logic [phcl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [phcl_pkg::CFG_DATA_W-1:0]      cfg_data,
  output      logic                                 done,
  output      phcl_pkg::result_t                    result
);

  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned REM_W   = BKT_W + 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ENTRY_W = $bits(phcl_pkg::entry_t);
  localparam int unsigned ROW_W   = WAYS * ENTRY_W;
  localparam logic [REM_W-1:0] BKT_CNT  = REM_W'(BUCKETS);
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

  // Scaled reciprocal of BUCKETS for an exact 32-bit quotient.
  localparam logic [63:0] RECIP_FULL = (64'd1 << (32 + BKT_W)) / 64'(BUCKETS);
  localparam logic [31:0] RECIP_M    = 32'(RECIP_FULL - (64'd1 << 32) + 64'd1);
  localparam int unsigned QUO_SHIFT  = BKT_W - 1;
  localparam logic [31:0] BKT_MULT   = 32'(BUCKETS);
  localparam logic [phcl_pkg::STEP_W-1:0] STEP_HIGH = phcl_pkg::STEP_W'(0);
  localparam logic [phcl_pkg::STEP_W-1:0] STEP_QUOT = phcl_pkg::STEP_W'(1);
  localparam logic [phcl_pkg::STEP_W-1:0] STEP_REM  =
    phcl_pkg::STEP_W'(phcl_pkg::MOD_STEPS - 1);

  // Configuration registers.
  logic [15:0] default_limit;
  logic [15:0] max_violations;
  logic [31:0] ban_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_limit  <= phcl_pkg::DEFAULT_LIMIT_RST;
      max_violations <= phcl_pkg::MAX_VIOL_RST;
      ban_seconds    <= phcl_pkg::BAN_SECONDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        phcl_pkg::CFG_DEFAULT_LIMIT:  default_limit  <= cfg_data[15:0];
        phcl_pkg::CFG_MAX_VIOLATIONS: max_violations <= cfg_data[15:0];
        phcl_pkg::CFG_BAN_SECONDS:    ban_seconds    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request.
  phcl_pkg::req_in_t req_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  // Hash: xor-shift, then one 32x32 multiply into a register.
  logic [31:0] hash_pre;
  logic [31:0] prod_q;

  assign hash_pre = req_q.host_key ^ {16'd0, req_q.host_key[31:16]};

  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      prod_q <= hash_pre * phcl_pkg::HASH_MULT;
    end
  end

  // Bucket index: remainder by BUCKETS through the reciprocal. The high half
  // of the product gives an estimate, a halving step corrects it into the
  // exact quotient, and the remainder follows with one constant multiply.
  logic [31:0]                 div_q;
  logic [63:0]                 recip_prod;
  logic [31:0]                 recip_hi_q;
  logic [31:0]                 quo_sum;
  logic [31:0]                 quo_q;
  logic [31:0]                 bkt_prod;
  logic [31:0]                 rem_full;
  logic [REM_W-1:0]            rem_q;
  logic [phcl_pkg::STEP_W-1:0] step_cnt;

  assign recip_prod = 64'(div_q) * 64'(RECIP_M);
  assign quo_sum    = recip_hi_q + ((div_q - recip_hi_q) >> 1);
  assign bkt_prod   = quo_q * BKT_MULT;
  assign rem_full   = div_q - bkt_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_q    <= '0;
      step_cnt <= '0;
    end else if (cmd.mod_init) begin
      rem_q    <= '0;
      step_cnt <= '0;
    end else if (cmd.mod_step) begin
      if (step_cnt == STEP_REM) begin
        rem_q <= rem_full[REM_W-1:0];
      end
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_step) begin
      if (step_cnt == STEP_HIGH) begin
        recip_hi_q <= recip_prod[63:32];
      end
      if (step_cnt == STEP_QUOT) begin
        quo_q <= quo_sum >> QUO_SHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      div_q <= prod_q ^ {16'd0, prod_q[31:16]};
    end
  end

  assign sts.mod_last = (step_cnt == STEP_REM);

  // Clearing pass address after reset.
  logic [BKT_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign sts.clear_last = (clr_addr == BKT_LAST);

  // Bucket memory: one row holds all ways of a bucket.
  phcl_pkg::entry_t [WAYS-1:0] row_rd;
  phcl_pkg::entry_t [WAYS-1:0] row_wr;
  logic [ROW_W-1:0]            ram_rdata;
  logic [ROW_W-1:0]            ram_wdata;
  logic [BKT_W-1:0]            ram_waddr;
  logic                        ram_we;
  logic                        wr_ok;

  assign row_rd    = ram_rdata;
  assign ram_wdata = cmd.clear ? '0 : ROW_W'(row_wr);
  assign ram_waddr = cmd.clear ? clr_addr : rem_q[BKT_W-1:0];
  assign ram_we    = cmd.clear || (cmd.update && wr_ok);

  phcl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read),
    .raddr (rem_q[BKT_W-1:0]),
    .rdata (ram_rdata)
  );

  // Lookup: matching way first, else the lowest free way.
  logic [WAYS-1:0]  hit_vec;
  logic [WAYS-1:0]  free_vec;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = row_rd[w].valid && (row_rd[w].key == req_q.host_key);
      free_vec[w] = !row_rd[w].valid;
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  logic             hit_q;
  logic             free_q;
  logic [WAY_W-1:0] way_q;
  phcl_pkg::entry_t ent_q;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_q  <= |hit_vec;
      free_q <= |free_vec;
      way_q  <= (|hit_vec) ? hit_way : free_way;
      ent_q  <= row_rd[(|hit_vec) ? hit_way : free_way];
    end
  end

  // Update: new entry contents and the result of the request.
  phcl_pkg::entry_t  ent_new;
  phcl_pkg::result_t res_next;
  logic [15:0]       new_limit;

  assign new_limit = req_q.has_exception ? req_q.exception_limit : default_limit;

  always_comb begin
    phcl_pkg::entry_t base;
    logic [15:0]      viol_inc;
    base     = ent_q;
    viol_inc = '0;
    ent_new  = ent_q;
    res_next = '0;
    wr_ok    = 1'b0;
    unique case (req_q.req_type)
      phcl_pkg::REQ_CONNECT: begin
        if (!hit_q && !free_q) begin
          res_next.action = phcl_pkg::ACT_FULL;
        end else begin
          wr_ok = 1'b1;
          if (!hit_q) begin
            base.valid = 1'b1;
            base.key   = req_q.host_key;
            base.count = '0;
            base.limit = new_limit;
            base.viol  = '0;
          end
          ent_new = base;
          if (base.count != phcl_pkg::CNT_MAX) begin
            ent_new.count = base.count + 1'b1;
          end
          res_next.exempt_flag = (base.limit > default_limit);
          res_next.entry_found = hit_q;
          if ((base.limit != '0) && (ent_new.count > base.limit)) begin
            if (max_violations == '0) begin
              res_next.action = phcl_pkg::ACT_KILL;
            end else begin
              viol_inc = base.viol;
              if (base.viol != phcl_pkg::CNT_MAX) begin
                viol_inc = base.viol + 1'b1;
              end
              ent_new.viol = viol_inc;
              if (viol_inc < max_violations) begin
                res_next.action = phcl_pkg::ACT_KILL;
              end else begin
                res_next.action   = phcl_pkg::ACT_BAN;
                res_next.ban_time = ban_seconds;
              end
            end
          end
          res_next.conn_count      = ent_new.count;
          res_next.entry_limit     = ent_new.limit;
          res_next.violation_count = ent_new.viol;
        end
      end
      phcl_pkg::REQ_DISCONNECT: begin
        if (hit_q) begin
          wr_ok = 1'b1;
          if (ent_q.count != '0) begin
            ent_new.count = ent_q.count - 1'b1;
          end
          ent_new.valid            = (ent_new.count != '0);
          res_next.entry_found     = 1'b1;
          res_next.conn_count      = ent_new.count;
          res_next.entry_limit     = ent_new.limit;
          res_next.violation_count = ent_new.viol;
        end
      end
      phcl_pkg::REQ_SET_LIMIT: begin
        if (hit_q) begin
          wr_ok                    = 1'b1;
          ent_new.limit            = new_limit;
          res_next.entry_found     = 1'b1;
          res_next.conn_count      = ent_new.count;
          res_next.entry_limit     = new_limit;
          res_next.violation_count = ent_new.viol;
        end
      end
      default: ;
    endcase
  end

  // Write-back row: the selected way replaced by the updated entry.
  always_comb begin
    row_wr = row_rd;
    row_wr[way_q] = ent_new;
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result <= res_next;
    end
  end

  // The bucket index stays within the table.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    rem_q < BKT_CNT)
    else $error("bucket remainder out of range");

  // A full bucket is reported with an empty result and changes nothing.
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    done && (result.action == phcl_pkg::ACT_FULL) |->
      !result.entry_found && (result.conn_count == '0) && $past(!ram_we))
    else $error("table full result is not empty or the table was written");

  // A ban time is reported only with a ban.
  a_ban_time: assert property (@(posedge clk) disable iff (rst)
    done && (result.action != phcl_pkg::ACT_BAN) |-> (result.ban_time == '0))
    else $error("ban time reported without a ban");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NUM_BUCKETS = 256;
  localparam int unsigned NUM_WAYS = 4;
  localparam int unsigned NUM_SLOTS = NUM_BUCKETS * NUM_WAYS;
  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned PHASE_ITEMS = 210;
  localparam int unsigned SAT_ITEMS = 40;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 40;
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam logic [phcl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  phcl_pkg::req_in_t req = '0;
  logic done;
  phcl_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [phcl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [phcl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  per_host_connection_limiter_top #(
    .BUCKETS(NUM_BUCKETS),
    .WAYS(NUM_WAYS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the host table and the configuration registers.
  bit tbl_valid[NUM_SLOTS];
  logic [31:0] tbl_key[NUM_SLOTS];
  logic [15:0] tbl_count[NUM_SLOTS];
  logic [15:0] tbl_limit[NUM_SLOTS];
  logic [15:0] tbl_viol[NUM_SLOTS];
  logic [15:0] dflt_limit_q = phcl_pkg::DEFAULT_LIMIT_RST;
  logic [15:0] max_viol_q = phcl_pkg::MAX_VIOL_RST;
  logic [31:0] ban_secs_q = phcl_pkg::BAN_SECONDS_RST;

  phcl_pkg::result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned full_bucket = 0;
  bit idle_enable = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Bucket index of a host key: xor-shift, multiply, xor-shift, then modulo.
  function automatic int unsigned bucket_of_key(logic [31:0] k);
    logic [31:0] h;
    h = k ^ (k >> 16);
    h = h * phcl_pkg::HASH_MULT;
    h = h ^ (h >> 16);
    return h % NUM_BUCKETS;
  endfunction

  // Applies one request to the shadow table and returns the result it causes.
  function automatic phcl_pkg::result_t predict_result(phcl_pkg::req_in_t r);
    phcl_pkg::result_t res;
    int unsigned base;
    int slot;
    int w;
    bit found;
    logic [15:0] new_limit;
    res = '0;
    if (r.req_type == REQ_RESERVED) return res;
    base = bucket_of_key(r.host_key) * NUM_WAYS;
    slot = -1;
    for (w = 0; w < NUM_WAYS; w++)
      if (slot < 0 && tbl_valid[base + w] && tbl_key[base + w] == r.host_key) slot = base + w;
    found = (slot >= 0);
    new_limit = r.has_exception ? r.exception_limit : dflt_limit_q;
    if (r.req_type == phcl_pkg::REQ_CONNECT) begin
      if (!found) begin
        for (w = 0; w < NUM_WAYS; w++)
          if (slot < 0 && !tbl_valid[base + w]) slot = base + w;
        if (slot < 0) begin
          res.action = phcl_pkg::ACT_FULL;
          return res;
        end
        tbl_valid[slot] = 1'b1;
        tbl_key[slot] = r.host_key;
        tbl_count[slot] = '0;
        tbl_limit[slot] = new_limit;
        tbl_viol[slot] = '0;
      end
      if (tbl_count[slot] != phcl_pkg::CNT_MAX) tbl_count[slot]++;
      res.exempt_flag = tbl_limit[slot] > dflt_limit_q;
      res.entry_found = found;
      // Over the limit: kill, or ban once the violations reach the maximum.
      if (tbl_limit[slot] != 0 && tbl_count[slot] > tbl_limit[slot]) begin
        if (max_viol_q == 0) begin
          res.action = phcl_pkg::ACT_KILL;
        end else begin
          if (tbl_viol[slot] != phcl_pkg::CNT_MAX) tbl_viol[slot]++;
          if (tbl_viol[slot] < max_viol_q) begin
            res.action = phcl_pkg::ACT_KILL;
          end else begin
            res.action = phcl_pkg::ACT_BAN;
            res.ban_time = ban_secs_q;
          end
        end
      end
    end else begin
      if (!found) return res;
      res.entry_found = 1'b1;
      if (r.req_type == phcl_pkg::REQ_DISCONNECT) begin
        if (tbl_count[slot] != 0) tbl_count[slot]--;
        if (tbl_count[slot] == 0) tbl_valid[slot] = 1'b0;
      end else begin
        tbl_limit[slot] = new_limit;
      end
    end
    res.conn_count = tbl_count[slot];
    res.entry_limit = tbl_limit[slot];
    res.violation_count = tbl_viol[slot];
    return res;
  endfunction

  function automatic phcl_pkg::req_in_t make_req(logic [1:0] kind, logic [31:0] key,
                                                 logic has_ex, logic [15:0] ex_lim);
    phcl_pkg::req_in_t r;
    r.req_type = kind;
    r.host_key = key;
    r.has_exception = has_ex;
    r.exception_limit = ex_lim;
    return r;
  endfunction

  // Random host key that lands in the given bucket.
  function automatic logic [31:0] key_in_bucket(int unsigned b);
    logic [31:0] k;
    do k = $urandom; while (bucket_of_key(k) != b);
    return k;
  endfunction

  // Mostly small limits so that connects cross them, sometimes any value.
  function automatic logic [15:0] pick_limit();
    if ($urandom_range(99) < 70) return 16'($urandom_range(6));
    return 16'($urandom);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin
    phcl_pkg::result_t exp_res;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: result with none expected, actual %0h", $time, result);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("action", exp_res.action, result.action);
        check_field("exempt_flag", exp_res.exempt_flag, result.exempt_flag);
        check_field("entry_found", exp_res.entry_found, result.entry_found);
        check_field("conn_count", exp_res.conn_count, result.conn_count);
        check_field("entry_limit", exp_res.entry_limit, result.entry_limit);
        check_field("violation_count", exp_res.violation_count, result.violation_count);
        check_field("ban_time", exp_res.ban_time, result.ban_time);
      end
    end
  end

  // Watchdog: cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Sends one request, sometimes with a random idle gap first, and records its expectation.
  task automatic send_request(phcl_pkg::req_in_t r);
    int unsigned gap;
    if (idle_enable && $urandom_range(99) < 28) begin
      gap = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_result(r));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [phcl_pkg::CFG_IDX_W-1:0] idx,
                           logic [phcl_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      phcl_pkg::CFG_DEFAULT_LIMIT: dflt_limit_q = data[15:0];
      phcl_pkg::CFG_MAX_VIOLATIONS: max_viol_q = data[15:0];
      phcl_pkg::CFG_BAN_SECONDS: ban_secs_q = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] dflt, logic [31:0] max_viol, logic [31:0] ban);
    wait_idle();
    write_reg(phcl_pkg::CFG_DEFAULT_LIMIT, dflt);
    write_reg(phcl_pkg::CFG_MAX_VIOLATIONS, max_viol);
    write_reg(phcl_pkg::CFG_BAN_SECONDS, ban);
  endtask

  // Reset configuration: three connections pass, then kills, and the fifth
  // violation bans. Unlimited and exempt hosts are covered too.
  task automatic test_limits_and_ban();
    logic [31:0] k;
    k = $urandom;
    // The exception limit is ignored without the exception flag.
    repeat (8) send_request(make_req(phcl_pkg::REQ_CONNECT, k, 1'b0, 16'hFFFF));
    k = $urandom;
    repeat (4) send_request(make_req(phcl_pkg::REQ_CONNECT, k, 1'b1, 16'h0000));
    send_request(make_req(phcl_pkg::REQ_CONNECT, $urandom, 1'b1, 16'hFFFF));
    k = $urandom;
    repeat (2) send_request(make_req(phcl_pkg::REQ_CONNECT, k, 1'b1, 16'h0001));
  endtask

  task automatic test_disconnect_and_set_limit();
    logic [31:0] k;
    k = $urandom;
    repeat (2) send_request(make_req(phcl_pkg::REQ_CONNECT, k, 1'b0, '0));
    send_request(make_req(phcl_pkg::REQ_SET_LIMIT, k, 1'b1, 16'd10));
    send_request(make_req(phcl_pkg::REQ_SET_LIMIT, k, 1'b0, 16'd10));
    send_request(make_req(REQ_RESERVED, k, 1'b1, 16'hFFFF));
    // The second disconnect frees the entry; afterwards the host is unknown.
    repeat (3) send_request(make_req(phcl_pkg::REQ_DISCONNECT, k, 1'b0, '0));
    send_request(make_req(phcl_pkg::REQ_SET_LIMIT, k, 1'b1, 16'd7));
  endtask

  // Five hosts in one bucket: the fifth finds no free way until one leaves.
  task automatic test_table_full();
    logic [31:0] keys[5];
    full_bucket = $urandom_range(NUM_BUCKETS - 1);
    foreach (keys[i]) begin
      keys[i] = key_in_bucket(full_bucket);
      send_request(make_req(phcl_pkg::REQ_CONNECT, keys[i], 1'b0, '0));
    end
    send_request(make_req(phcl_pkg::REQ_DISCONNECT, keys[0], 1'b0, '0));
    send_request(make_req(phcl_pkg::REQ_CONNECT, keys[4], 1'b0, '0));
  endtask

  // With a maximum of zero violations the block only kills.
  task automatic test_never_ban();
    logic [31:0] k;
    set_config(32'd1, 32'd0, $urandom);
    k = $urandom;
    repeat (4) send_request(make_req(phcl_pkg::REQ_CONNECT, k, 1'b0, '0));
  endtask

  task automatic test_random();
    logic [31:0] pool[POOL_SIZE];
    logic [31:0] k;
    logic [15:0] lim;
    logic has_ex;
    int unsigned pool_bucket;
    int unsigned items;
    int unsigned len;
    int unsigned pick;
    pool_bucket = $urandom_range(NUM_BUCKETS - 1);
    foreach (pool[i]) pool[i] = (i < 6) ? key_in_bucket(pool_bucket) : $urandom;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_config(32'd3, 32'd5, $urandom);
        1: set_config(32'd1, 32'd2, $urandom);
        2: set_config(32'd0, 32'd0, 32'd0);
        3: set_config(32'h0000FFFF, 32'h0000FFFF, 32'hFFFFFFFF);
        default: begin
          // Upper data bits above a 16-bit register are dropped.
          set_config({16'($urandom), 16'($urandom_range(4))},
                     {16'($urandom), 16'($urandom_range(1, 3))}, $urandom);
          write_reg(CFG_UNUSED, $urandom);
        end
      endcase
      // One phase runs back to back with no idle cycles at all.
      idle_enable = (phase != 2);
      items = 0;
      while (items < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        k = ($urandom_range(99) < 88) ? pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
        has_ex = $urandom_range(1);
        lim = pick_limit();
        if (pick < 45) begin
          len = $urandom_range(1, 6);
          repeat (len) send_request(make_req(phcl_pkg::REQ_CONNECT, k, has_ex, lim));
        end else if (pick < 80) begin
          len = $urandom_range(1, 8);
          repeat (len) send_request(make_req(phcl_pkg::REQ_DISCONNECT, k, has_ex, lim));
        end else if (pick < 94) begin
          len = 1;
          send_request(make_req(phcl_pkg::REQ_SET_LIMIT, k, has_ex, lim));
        end else begin
          len = 1;
          send_request(make_req(2'($urandom_range(3)), $urandom, has_ex, 16'($urandom)));
        end
        items += len;
      end
    end
    idle_enable = 1'b1;
  endtask

  // Limit one and a ban threshold out of reach: an unbroken run of connects,
  // each after the first over the limit and answered with kill while the counts climb.
  task automatic test_saturation();
    logic [31:0] k;
    set_config(32'd3, 32'h0000FFFF, 32'hFFFFFFFF);
    do k = $urandom; while (bucket_of_key(k) == full_bucket);
    idle_enable = 1'b0;
    repeat (SAT_ITEMS) send_request(make_req(phcl_pkg::REQ_CONNECT, k, 1'b1, 16'd1));
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_limits_and_ban();
    test_disconnect_and_set_limit();
    test_table_full();
    test_never_ban();
    test_random();
    test_saturation();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: per_host_connection_limiter_top.f
sv/phcl_pkg.sv
sv/phcl_ram.sv
sv/phcl_ctrl.sv
sv/phcl_dpath.sv
sv/per_host_connection_limiter_top.sv
tb/sv/testbench.sv
